// File: design/mts_pkg.sv
`default_nettype none

package mts_pkg;

	// Default structural parameters.
	localparam int MAX_NOTES_DEF   = 256;
	localparam int VOLUME_BITS_DEF = 16;

	// Field widths.
	localparam int HZ_W      = 15;
	localparam int BEATS_W   = 8;
	localparam int INDEX_W   = 8;
	localparam int PERIOD_W  = 16;
	localparam int SONG_W    = 9;
	localparam int CLOCK_W   = 24;
	localparam int CFG16_W   = 16;
	localparam int DECAY_FRAC = 16;

	// Configuration port.
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	localparam logic [2:0] REG_SONG_LENGTH    = 3'd0;
	localparam logic [2:0] REG_TIMER_CLOCK_HZ = 3'd1;
	localparam logic [2:0] REG_NORMAL_VOLUME  = 3'd2;
	localparam logic [2:0] REG_MIN_VOLUME     = 3'd3;
	localparam logic [2:0] REG_DECAY_FACTOR   = 3'd4;

	// Register reset values.
	localparam logic [SONG_W-1:0]   SONG_LENGTH_RST  = 9'd256;
	localparam logic [CLOCK_W-1:0]  TIMER_CLOCK_RST  = 24'd375000;
	localparam logic [CFG16_W-1:0]  NORMAL_VOL_RST   = 16'd32768;
	localparam logic [CFG16_W-1:0]  MIN_VOL_RST      = 16'd328;
	localparam logic [CFG16_W-1:0]  DECAY_RST        = 16'd59770;

	// Playback state reset values.
	localparam logic [31:0]         VOLUME_RST       = 32'd32768;
	localparam logic [PERIOD_W-1:0] PERIOD_RST       = 16'd7500;
	localparam int                  PLAY_INDEX_RST   = 255;

	// Request action codes.
	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_LOAD = 1'b1;

	typedef struct packed {
		logic                 action;
		logic [INDEX_W-1:0]   entry_index;
		logic [HZ_W-1:0]      entry_hz;
		logic [BEATS_W-1:0]   entry_beats;
		logic                 entry_pause;
	} cmd_t;

	typedef struct packed {
		logic [PERIOD_W-1:0]  period_count;
		logic [PERIOD_W-1:0]  compare_count;
		logic [INDEX_W-1:0]   note_index;
		logic                 note_started;
		logic                 is_silent;
	} tone_t;

	typedef struct packed {
		logic [HZ_W-1:0]      hz;
		logic [BEATS_W-1:0]   beats;
		logic                 pause;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECAY,
		S_READ,
		S_ENTRY,
		S_DIV,
		S_CMP_GO,
		S_CMP,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

// File: design/mts_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module mts_div
	import mts_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [CLOCK_W-1:0] dividend,
	input  wire logic [HZ_W-1:0]    divisor,
	output logic                    done,
	output logic [CLOCK_W-1:0]      quotient
);

	localparam int CNT_W = $clog2(CLOCK_W);

	logic [CLOCK_W-1:0] shift_q;
	logic [HZ_W-1:0]    rem_q;
	logic [HZ_W-1:0]    div_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;

	logic [HZ_W:0]      trial;
	logic [HZ_W:0]      diff;
	logic               fits;

	// Bring down the next dividend bit and try a subtraction.
	always_comb begin
		trial = {rem_q, shift_q[CLOCK_W-1]};
		diff  = trial - {1'b0, div_q};
		fits  = trial >= {1'b0, div_q};
	end

	// Control: a count of remaining steps and a one-cycle done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end else if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(CLOCK_W - 1);
			end
		end
	end

	// Datapath: the dividend register collects quotient bits from the bottom.
	always_ff @(posedge clk) begin
		if (busy_q) begin
			rem_q   <= fits ? diff[HZ_W-1:0] : trial[HZ_W-1:0];
			shift_q <= {shift_q[CLOCK_W-2:0], fits};
		end else if (start) begin
			rem_q   <= '0;
			shift_q <= dividend;
			div_q   <= divisor;
		end
	end

	assign done     = done_q;
	assign quotient = shift_q;

endmodule

`default_nettype wire

// File: design/mts_mul.sv
`default_nettype none

// Shift-add multiplier, one multiplier bit per cycle.
module mts_mul
	import mts_pkg::*;
#(
	parameter int WIDTH = VOLUME_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [WIDTH-1:0]   a,
	input  wire logic [WIDTH-1:0]   b,
	output logic                    done,
	output logic [2*WIDTH-1:0]      product
);

	localparam int CNT_W = $clog2(WIDTH);

	logic [WIDTH-1:0] hi_q;
	logic [WIDTH-1:0] lo_q;
	logic [WIDTH-1:0] a_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [WIDTH:0]   sum;

	// Add the multiplicand when the current multiplier bit is set.
	always_comb begin
		sum = lo_q[0] ? ({1'b0, hi_q} + {1'b0, a_q}) : {1'b0, hi_q};
	end

	// Control: step count and a one-cycle done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end else if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(WIDTH - 1);
			end
		end
	end

	// Datapath: partial product shifts right through the multiplier register.
	always_ff @(posedge clk) begin
		if (busy_q) begin
			{hi_q, lo_q} <= {sum, lo_q[WIDTH-1:1]};
		end else if (start) begin
			hi_q <= '0;
			lo_q <= b;
			a_q  <= a;
		end
	end

	assign done    = done_q;
	assign product = {hi_q, lo_q};

endmodule

`default_nettype wire

// File: design/melody_tone_sequencer.sv
`default_nettype none

// Channel   Direction  Payload  Handshake
// cmd       in         cmd_t    cmd_valid / cmd_stall
// tone      out        tone_t   tone_valid / tone_stall
// apb       in/out     32-bit   psel / penable / pwrite, pready tied high
//
// One request at a time. A load gives no result. A tick that stays on its note
// runs two serial multiplies of MW = max(VOLUME_BITS,16) steps; a tick that
// starts a tone runs the 24-step serial divider and one multiply, only the
// multiply for a zero frequency, and neither for a pause.
// Reset clears all control state; the note memory holds garbage until loaded.
// A stalled result stays in the output register while the next request is taken.
module melody_tone_sequencer
	import mts_pkg::*;
#(
	parameter int MAX_NOTES   = MAX_NOTES_DEF,
	parameter int VOLUME_BITS = VOLUME_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,

	input  wire logic                cmd_valid,
	output logic                     cmd_stall,
	input  wire cmd_t                cmd,

	output logic                     tone_valid,
	input  wire logic                tone_stall,
	output tone_t                    tone,

	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [PADDR_W-1:0]  paddr,
	input  wire logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]       prdata,
	output logic                     pready
);

	localparam int IW = $clog2(MAX_NOTES);
	localparam int LW = (IW + 1 > SONG_W) ? IW + 1 : SONG_W;
	localparam int VB = VOLUME_BITS;
	localparam int MW = (VB > DECAY_FRAC) ? VB : DECAY_FRAC;

	// Configuration registers.
	logic [SONG_W-1:0]  song_length_q;
	logic [CLOCK_W-1:0] timer_clock_q;
	logic [CFG16_W-1:0] normal_volume_q;
	logic [CFG16_W-1:0] min_volume_q;
	logic [CFG16_W-1:0] decay_factor_q;

	// Playback state.
	logic [IW-1:0]       play_index_q;
	logic [BEATS_W-1:0]  beats_left_q;
	logic [VB-1:0]       volume_q;
	logic [PERIOD_W-1:0] period_q;
	logic                silent_q;
	logic                started_q;
	logic [PERIOD_W-1:0] compare_q;

	state_t state_q;
	state_t state_d;

	// Note memory.
	entry_t mem [MAX_NOTES];
	entry_t entry_q;

	// Output register.
	logic  tone_valid_q;
	tone_t tone_q;

	logic                cmd_fire;
	logic                tick_fire;
	logic                load_fire;
	logic                advance;
	logic [LW-1:0]       lim;
	logic [LW-1:0]       nx_wide;
	logic [IW-1:0]       nx;
	logic [VB-1:0]       min_v;
	logic [VB-1:0]       normal_v;
	logic [VB-1:0]       vol_floor;
	logic                out_free;
	logic [2:0]          reg_idx;
	logic                cfg_wr;

	logic                mul_start;
	logic [MW-1:0]       mul_a;
	logic [MW-1:0]       mul_b;
	logic                mul_done;
	logic [2*MW-1:0]     mul_prod;

	logic                div_start;
	logic                div_done;
	logic [CLOCK_W-1:0]  div_quot;
	logic [CLOCK_W-1:0]  quot_m1;
	logic [PERIOD_W-1:0] period_sat;

	// Request decode and next-index arithmetic.
	always_comb begin
		cmd_fire  = cmd_valid && !cmd_stall;
		tick_fire = cmd_fire && (cmd.action == ACT_TICK);
		load_fire = cmd_fire && (cmd.action == ACT_LOAD);
		advance   = beats_left_q <= BEATS_W'(1);
		lim       = (LW'(song_length_q) < LW'(MAX_NOTES)) ? LW'(song_length_q)
		                                                  : LW'(MAX_NOTES);
		nx_wide   = LW'(play_index_q) + LW'(1);
		nx        = (nx_wide >= lim) ? '0 : nx_wide[IW-1:0];
		min_v     = VB'(min_volume_q);
		normal_v  = VB'(normal_volume_q);
		vol_floor = (volume_q < min_v) ? min_v : volume_q;
		out_free  = !tone_valid_q || !tone_stall;
	end

	// Period from the quotient: zero stays zero, otherwise minus one, saturated.
	always_comb begin
		quot_m1 = div_quot - CLOCK_W'(1);
		if (div_quot == '0) begin
			period_sat = '0;
		end else if (|quot_m1[CLOCK_W-1:PERIOD_W]) begin
			period_sat = '1;
		end else begin
			period_sat = quot_m1[PERIOD_W-1:0];
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (tick_fire) begin
					state_d = advance ? S_READ : S_DECAY;
				end
			end
			S_DECAY: begin
				if (mul_done) begin
					state_d = S_CMP_GO;
				end
			end
			S_READ: state_d = S_ENTRY;
			S_ENTRY: begin
				if (entry_q.pause) begin
					state_d = S_DONE;
				end else if (entry_q.hz == '0) begin
					state_d = S_CMP_GO;
				end else begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (div_done) begin
					state_d = S_CMP_GO;
				end
			end
			S_CMP_GO: state_d = S_CMP;
			S_CMP: begin
				if (mul_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State outputs: handshake and unit starts with operand selection.
	always_comb begin
		cmd_stall = 1'b1;
		mul_start = 1'b0;
		div_start = 1'b0;
		mul_a     = MW'(period_q);
		mul_b     = MW'(volume_q);
		unique case (state_q)
			S_IDLE: begin
				cmd_stall = 1'b0;
				mul_start = tick_fire && !advance;
				mul_a     = MW'(vol_floor);
				mul_b     = MW'(decay_factor_q);
			end
			S_ENTRY: begin
				div_start = !entry_q.pause && (entry_q.hz != '0);
			end
			S_CMP_GO: begin
				mul_start = 1'b1;
			end
			S_DECAY, S_READ, S_DIV, S_CMP, S_DONE: begin
				cmd_stall = 1'b1;
			end
			default: cmd_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Playback state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			play_index_q <= IW'(PLAY_INDEX_RST);
			beats_left_q <= '0;
			volume_q     <= VB'(VOLUME_RST);
			period_q     <= PERIOD_RST;
			silent_q     <= 1'b0;
			started_q    <= 1'b0;
			compare_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (tick_fire) begin
						started_q <= advance;
						if (advance) begin
							play_index_q <= nx;
							volume_q     <= normal_v;
						end else begin
							beats_left_q <= beats_left_q - 1'b1;
						end
					end
				end
				S_DECAY: begin
					if (mul_done) begin
						volume_q <= mul_prod[DECAY_FRAC +: VB];
					end
				end
				S_ENTRY: begin
					beats_left_q <= entry_q.beats;
					silent_q     <= entry_q.pause;
					if (entry_q.pause) begin
						compare_q <= '0;
					end else if (entry_q.hz == '0) begin
						period_q <= '1;
					end
				end
				S_DIV: begin
					if (div_done) begin
						period_q <= period_sat;
					end
				end
				S_CMP: begin
					if (mul_done) begin
						compare_q <= silent_q ? '0 : mul_prod[VB +: PERIOD_W];
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Note memory: one write port for loads, one registered read port.
	always_ff @(posedge clk) begin
		if (load_fire && (32'(cmd.entry_index) < MAX_NOTES)) begin
			mem[IW'(cmd.entry_index)] <= '{hz: cmd.entry_hz, beats: cmd.entry_beats,
			                              pause: cmd.entry_pause};
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= mem[play_index_q];
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			tone_valid_q <= 1'b1;
		end else if (!tone_stall) begin
			tone_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			tone_q.period_count  <= period_q;
			tone_q.compare_count <= compare_q;
			tone_q.note_index    <= INDEX_W'(play_index_q);
			tone_q.note_started  <= started_q;
			tone_q.is_silent     <= silent_q;
		end
	end

	assign tone_valid = tone_valid_q;
	assign tone       = tone_q;

	// Configuration registers.
	assign reg_idx = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			song_length_q   <= SONG_LENGTH_RST;
			timer_clock_q   <= TIMER_CLOCK_RST;
			normal_volume_q <= NORMAL_VOL_RST;
			min_volume_q    <= MIN_VOL_RST;
			decay_factor_q  <= DECAY_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_SONG_LENGTH:    song_length_q   <= pwdata[SONG_W-1:0];
				REG_TIMER_CLOCK_HZ: timer_clock_q   <= pwdata[CLOCK_W-1:0];
				REG_NORMAL_VOLUME:  normal_volume_q <= pwdata[CFG16_W-1:0];
				REG_MIN_VOLUME:     min_volume_q    <= pwdata[CFG16_W-1:0];
				REG_DECAY_FACTOR:   decay_factor_q  <= pwdata[CFG16_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (reg_idx)
			REG_SONG_LENGTH:    prdata = PDATA_W'(song_length_q);
			REG_TIMER_CLOCK_HZ: prdata = PDATA_W'(timer_clock_q);
			REG_NORMAL_VOLUME:  prdata = PDATA_W'(normal_volume_q);
			REG_MIN_VOLUME:     prdata = PDATA_W'(min_volume_q);
			REG_DECAY_FACTOR:   prdata = PDATA_W'(decay_factor_q);
			default:            prdata = '0;
		endcase
	end

	// Arithmetic units.
	mts_mul #(
		.WIDTH (MW)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.product (mul_prod)
	);

	mts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (timer_clock_q),
		.divisor  (entry_q.hz),
		.done     (div_done),
		.quotient (div_quot)
	);

	// A load request never starts the tick sequence.
	a_load_no_work: assert property (@(posedge clk) disable iff (!arst_n)
		load_fire |=> state_q == S_IDLE)
		else $error("load request started tick processing");

	// Multiplier results arrive only where the sequence expects them.
	a_mul_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == S_DECAY || state_q == S_CMP))
		else $error("multiplier finished outside a multiply state");

	// Divider results arrive only while waiting for the period.
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside the divide state");

	// A silent result always carries a zero compare value.
	a_silent_zero: assert property (@(posedge clk) disable iff (!arst_n)
		tone_valid && tone.is_silent |-> tone.compare_count == '0)
		else $error("silent note produced a nonzero compare value");

	// Each new result follows a finished tick sequence.
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(tone_valid) |-> $past(state_q) == S_DONE)
		else $error("result appeared without a finished tick");

endmodule

`default_nettype wire

// File: dv/melody_tone_sequencer_tb.sv
`timescale 1ns / 1ps

module melody_tone_sequencer_tb
	import mts_pkg::*;
();

	// Idle cycles after the last result, enough for a load or a tick still in flight.
	localparam int SETTLE_CYCLES = 80;
	localparam int MAX_REPORTS   = 10;

	// Register indexes with no register behind them.
	localparam logic [2:0] REG_SPARE_LO = 3'd5;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	// Models the note table, the envelope and the beat counter, and queues the tones they produce.
	class tone_scoreboard;
		logic [HZ_W-1:0]     note_hz    [MAX_NOTES_DEF];
		logic [BEATS_W-1:0]  note_beats [MAX_NOTES_DEF];
		logic                note_pause [MAX_NOTES_DEF];
		bit                  loaded     [MAX_NOTES_DEF];
		logic [SONG_W-1:0]   song_length;
		logic [CLOCK_W-1:0]  timer_clock_hz;
		logic [CFG16_W-1:0]  normal_volume;
		logic [CFG16_W-1:0]  min_volume;
		logic [CFG16_W-1:0]  decay_factor;
		logic [INDEX_W-1:0]  play_index;
		logic [BEATS_W-1:0]  beats_left;
		logic [15:0]         volume_level;
		logic [PERIOD_W-1:0] period_value;
		logic                silent;
		tone_t               expected_tones[$];
		int                  mismatches;

		function new();
			foreach (loaded[i]) begin
				loaded[i] = 1'b0;
			end
			song_length    = SONG_LENGTH_RST;
			timer_clock_hz = TIMER_CLOCK_RST;
			normal_volume  = NORMAL_VOL_RST;
			min_volume     = MIN_VOL_RST;
			decay_factor   = DECAY_RST;
			play_index     = '1;
			beats_left     = '0;
			volume_level   = VOLUME_RST[15:0];
			period_value   = PERIOD_RST;
			silent         = 1'b0;
			mismatches     = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [PDATA_W-1:0] value);
			case (idx)
				REG_SONG_LENGTH:    song_length    = value[SONG_W-1:0];
				REG_TIMER_CLOCK_HZ: timer_clock_hz = value[CLOCK_W-1:0];
				REG_NORMAL_VOLUME:  normal_volume  = value[CFG16_W-1:0];
				REG_MIN_VOLUME:     min_volume     = value[CFG16_W-1:0];
				REG_DECAY_FACTOR:   decay_factor   = value[CFG16_W-1:0];
				default: ;
			endcase
		endfunction

		function logic [PDATA_W-1:0] reg_value(logic [2:0] idx);
			case (idx)
				REG_SONG_LENGTH:    return PDATA_W'(song_length);
				REG_TIMER_CLOCK_HZ: return PDATA_W'(timer_clock_hz);
				REG_NORMAL_VOLUME:  return PDATA_W'(normal_volume);
				REG_MIN_VOLUME:     return PDATA_W'(min_volume);
				REG_DECAY_FACTOR:   return PDATA_W'(decay_factor);
				default:            return '0;
			endcase
		endfunction

		function void check_reg(logic [2:0] idx, logic [PDATA_W-1:0] got);
			if (got !== reg_value(idx)) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("register %0d read back: expected %0d, got %0d",
						idx, reg_value(idx), got);
				end
			end
		endfunction

		// Number of entries that playback can reach with the present song length.
		function int play_span();
			int lim;
			lim = (song_length < MAX_NOTES_DEF) ? int'(song_length) : MAX_NOTES_DEF;
			return (lim == 0) ? 1 : lim;
		endfunction

		// First reachable entry that was never loaded, or -1 when all are.
		function int first_missing();
			int span;
			span = play_span();
			for (int i = 0; i < span; i++) begin
				if (!loaded[i]) begin
					return i;
				end
			end
			return -1;
		endfunction

		// Period value for a tone: clock / hz - 1, saturated to 16 bits; zero hz gives all ones.
		function logic [PERIOD_W-1:0] period_for(logic [HZ_W-1:0] hz);
			logic [CLOCK_W-1:0] q;
			if (hz == '0) begin
				return '1;
			end
			q = timer_clock_hz / CLOCK_W'(hz);
			if (q == '0) begin
				return '0;
			end
			q = q - CLOCK_W'(1);
			return (q > CLOCK_W'(16'hFFFF)) ? '1 : q[PERIOD_W-1:0];
		endfunction

		// Applies one accepted request; a tick queues the tone it should produce.
		function void note_request(cmd_t c);
			logic [31:0] prod;
			int          limit;
			int          nxt;
			tone_t       t;
			if (c.action == ACT_LOAD) begin
				note_hz[c.entry_index]    = c.entry_hz;
				note_beats[c.entry_index] = c.entry_beats;
				note_pause[c.entry_index] = c.entry_pause;
				loaded[c.entry_index]     = 1'b1;
				return;
			end

			// The envelope runs first: floor, then decay.
			if (volume_level < min_volume) begin
				volume_level = min_volume;
			end
			prod = 32'(volume_level) * 32'(decay_factor);
			volume_level = prod[31:16];

			// The beat counter moves on to the next entry once it runs out.
			t.note_started = 1'b0;
			if (beats_left <= BEATS_W'(1)) begin
				limit = (song_length < MAX_NOTES_DEF) ? int'(song_length) : MAX_NOTES_DEF;
				nxt = int'(play_index) + 1;
				if (nxt >= limit || nxt >= MAX_NOTES_DEF) begin
					nxt = 0;
				end
				play_index   = nxt[INDEX_W-1:0];
				volume_level = normal_volume;
				if (note_pause[nxt]) begin
					silent = 1'b1;
				end else begin
					silent       = 1'b0;
					period_value = period_for(note_hz[nxt]);
				end
				beats_left     = note_beats[nxt];
				t.note_started = 1'b1;
			end else begin
				beats_left = beats_left - BEATS_W'(1);
			end

			prod = 32'(period_value) * 32'(volume_level);
			t.period_count  = period_value;
			t.compare_count = silent ? '0 : prod[31:16];
			t.note_index    = play_index;
			t.is_silent     = silent;
			expected_tones.push_back(t);
		endfunction

		// Compares one accepted tone with the oldest expected one.
		function void check_tone(tone_t got);
			tone_t want;
			if (expected_tones.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("tone with no tick pending: period %0d compare %0d index %0d",
						got.period_count, got.compare_count, got.note_index);
				end
				return;
			end
			want = expected_tones.pop_front();
			if (got.period_count !== want.period_count ||
					got.compare_count !== want.compare_count ||
					got.note_index !== want.note_index ||
					got.note_started !== want.note_started ||
					got.is_silent !== want.is_silent) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("tone mismatch: expected period %0d compare %0d index %0d started %0b silent %0b",
						want.period_count, want.compare_count, want.note_index,
						want.note_started, want.is_silent);
					$display("               got      period %0d compare %0d index %0d started %0b silent %0b",
						got.period_count, got.compare_count, got.note_index,
						got.note_started, got.is_silent);
				end
			end
		endfunction
	endclass

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                cmd_valid  = 1'b0;
	logic                cmd_stall;
	cmd_t                cmd        = '0;
	logic                tone_valid;
	logic                tone_stall = 1'b0;
	tone_t               tone;
	logic                psel       = 1'b0;
	logic                penable    = 1'b0;
	logic                pwrite     = 1'b0;
	logic [PADDR_W-1:0]  paddr      = '0;
	logic [PDATA_W-1:0]  pwdata     = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	// One in N chance of an idle burst; zero turns idling off.
	int gap_odds   = 0;
	int stall_odds = 0;

	tone_scoreboard sb = new();

	melody_tone_sequencer i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_stall  (cmd_stall),
		.cmd        (cmd),
		.tone_valid (tone_valid),
		.tone_stall (tone_stall),
		.tone       (tone),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The result side stalls in random bursts.
	always @(posedge clk) begin
		if (arst_n && stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
			tone_stall <= 1'b1;
			repeat ($urandom_range(1, 17)) @(posedge clk);
			tone_stall <= 1'b0;
		end
	end

	// Every accepted tone is checked.
	always @(posedge clk) begin
		if (arst_n && tone_valid && !tone_stall) begin
			sb.check_tone(tone);
		end
	end

	// Writes one register through a setup and an access cycle, then reads it back.
	task automatic write_reg(logic [2:0] idx, logic [PDATA_W-1:0] value);
		logic [PDATA_W-1:0] seen;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, value);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		seen = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (idx <= REG_DECAY_FACTOR) begin
			sb.check_reg(idx, seen);
		end
	endtask

	task automatic configure(logic [SONG_W-1:0] song, logic [CLOCK_W-1:0] clock_hz,
			logic [CFG16_W-1:0] normal_vol, logic [CFG16_W-1:0] min_vol,
			logic [CFG16_W-1:0] decay);
		write_reg(REG_SONG_LENGTH, PDATA_W'(song));
		write_reg(REG_TIMER_CLOCK_HZ, PDATA_W'(clock_hz));
		write_reg(REG_NORMAL_VOLUME, PDATA_W'(normal_vol));
		write_reg(REG_MIN_VOLUME, PDATA_W'(min_vol));
		write_reg(REG_DECAY_FACTOR, PDATA_W'(decay));
	endtask

	// Offers one request, waits for it to be taken and sometimes idles after it.
	task automatic send_request(cmd_t c);
		cmd       <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
		sb.note_request(c);
		if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	// Holds off requests until every tone has come and the block has gone quiet.
	task automatic drain_results();
		cmd_valid <= 1'b0;
		while (sb.expected_tones.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic cmd_t load_entry(logic [INDEX_W-1:0] idx, logic [HZ_W-1:0] hz,
			logic [BEATS_W-1:0] beats, logic pause);
		cmd_t c;
		c.action      = ACT_LOAD;
		c.entry_index = idx;
		c.entry_hz    = hz;
		c.entry_beats = beats;
		c.entry_pause = pause;
		return c;
	endfunction

	// Load with random content; short notes are favored so that entries change often.
	function automatic cmd_t random_load(logic [INDEX_W-1:0] idx);
		logic [HZ_W-1:0]    hz;
		logic [BEATS_W-1:0] beats;
		case ($urandom_range(0, 9))
			0: hz = '0;
			1: hz = '1;
			2: hz = HZ_W'($urandom_range(0, 32767));
			default: hz = HZ_W'($urandom_range(6, 20000));
		endcase
		if ($urandom_range(0, 4) == 0) begin
			beats = BEATS_W'($urandom_range(0, 255));
		end else begin
			beats = BEATS_W'($urandom_range(0, 4));
		end
		return load_entry(idx, hz, beats, $urandom_range(0, 4) == 0);
	endfunction

	// Tick with random garbage in the fields it does not use.
	function automatic cmd_t random_tick();
		logic [63:0] bits;
		cmd_t        c;
		bits = {$urandom, $urandom};
		c = bits[$bits(cmd_t)-1:0];
		c.action = ACT_TICK;
		return c;
	endfunction

	// Random mix of ticks and loads; reachable entries are loaded before any tick.
	task automatic run_phase(int items);
		int   missing;
		cmd_t c;
		for (int n = 0; n < items; n++) begin
			missing = sb.first_missing();
			if (missing >= 0) begin
				c = random_load(INDEX_W'(missing));
			end else if ($urandom_range(0, 99) < 60) begin
				c = random_tick();
			end else if ($urandom_range(0, 3) != 0) begin
				c = random_load(INDEX_W'($urandom_range(0, sb.play_span() - 1)));
			end else begin
				c = random_load(INDEX_W'($urandom_range(0, 255)));
			end
			send_request(c);
			if (n == items / 2) begin
				drain_results();
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part on the reset settings with a four-entry song: zero frequency,
		// zero and single beats, a pause, the extreme frequencies and the last index.
		write_reg(REG_SONG_LENGTH, PDATA_W'(4));
		gap_odds   = 3;
		stall_odds = 5;
		send_request(load_entry(8'd0, 15'd440, 8'd2, 1'b0));
		send_request(load_entry(8'd1, 15'd0, 8'd0, 1'b0));
		send_request(load_entry(8'd2, 15'h7FFF, 8'd1, 1'b1));
		send_request(load_entry(8'd3, 15'd6, 8'd3, 1'b0));
		send_request(load_entry(8'd255, 15'd20000, 8'd255, 1'b0));
		repeat (14) send_request(random_tick());
		drain_results();

		// Random phases, each on its own settings.
		configure(9'd8, TIMER_CLOCK_RST, NORMAL_VOL_RST, MIN_VOL_RST, DECAY_RST);
		gap_odds   = 8;
		stall_odds = 8;
		run_phase(150);
		drain_results();

		configure(9'd1, 24'hFFFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
		gap_odds   = 4;
		stall_odds = 0;
		run_phase(120);
		drain_results();

		configure(9'd256, 24'd1, 16'd0, 16'hFFFF, 16'd0);
		gap_odds   = 0;
		stall_odds = 6;
		run_phase(350);
		drain_results();

		configure(9'd0, 24'd1000000, 16'd40000, 16'd100, 16'd30000);
		gap_odds   = 12;
		stall_odds = 12;
		run_phase(100);
		drain_results();

		configure(9'd300, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		gap_odds   = 6;
		stall_odds = 3;
		run_phase(120);
		drain_results();

		// Writes to the spare indexes must leave every register alone.
		write_reg(REG_SPARE_LO, $urandom);
		write_reg(REG_SPARE_HI, $urandom);
		configure(SONG_W'($urandom_range(1, 64)), CLOCK_W'($urandom_range(1, 24'hFFFFFF)),
			CFG16_W'($urandom), CFG16_W'($urandom), CFG16_W'($urandom));
		gap_odds   = 10;
		stall_odds = 10;
		run_phase(150);
		drain_results();

		// Last stretch runs back to back with no idling.
		configure(9'd256, CLOCK_W'($urandom_range(1000, 24'hFFFFFF)),
			CFG16_W'($urandom), CFG16_W'($urandom_range(0, 2000)),
			CFG16_W'($urandom_range(40000, 65535)));
		gap_odds   = 0;
		stall_odds = 0;
		run_phase(150);
		drain_results();

		if (sb.mismatches == 0 && sb.expected_tones.size() == 0) begin
			$display("melody_tone_sequencer test passed");
		end else begin
			$display("melody_tone_sequencer test failed");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("melody_tone_sequencer test failed");
		$finish;
	end

endmodule
